@@ src/bcd_pkg.sv @@
// Shared types and constants for the battery current derating block.
// Holds the payload beats, the breakpoint tables and the scaling constants.
// No dependencies.
package bcd_pkg;

  typedef struct packed {
    logic signed [11:0] max_temperature;
    logic [13:0]        charge_state;
    logic [12:0]        highest_cell_mv;
    logic [12:0]        lowest_cell_mv;
  } in_t;

  typedef struct packed {
    logic [19:0] charge_limit_ma;
    logic [19:0] discharge_limit_ma;
  } out_t;

  typedef struct packed {
    logic signed [14:0] bp;
    logic [8:0]         rt;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic       tag;
    logic [8:0] rate;
  } scale_req_t;

  typedef struct packed {
    logic        valid;
    logic        tag;
    logic [19:0] ma;
  } scale_rsp_t;

  localparam int TAB_N = 47;
  localparam int CURVES = 6;

  localparam logic signed [14:0] BP_TAB [TAB_N] = '{
    -15'sd250, 15'sd0, 15'sd50, 15'sd150, 15'sd350, 15'sd450, 15'sd550, 15'sd650,
    -15'sd250, -15'sd150, -15'sd100, -15'sd50, 15'sd0, 15'sd50, 15'sd100, 15'sd250,
    15'sd300, 15'sd350, 15'sd450, 15'sd550, 15'sd600, 15'sd650, 15'sd700,
    15'sd0, 15'sd8500, 15'sd9000, 15'sd9500, 15'sd10000,
    15'sd0, 15'sd200, 15'sd500, 15'sd800, 15'sd1000, 15'sd1500, 15'sd2000,
    15'sd5000, 15'sd10000,
    15'sd3000, 15'sd4100, 15'sd4200,
    15'sd3000, 15'sd3200, 15'sd3300, 15'sd3400, 15'sd3450, 15'sd3550, 15'sd4200
  };

  localparam logic [8:0] RT_TAB [TAB_N] = '{
    9'd0, 9'd0, 9'd0, 9'd300, 9'd300, 9'd200, 9'd0, 9'd0,
    9'd20, 9'd20, 9'd100, 9'd150, 9'd200, 9'd450, 9'd500, 9'd500,
    9'd450, 9'd400, 9'd380, 9'd380, 9'd20, 9'd20, 9'd0,
    9'd300, 9'd300, 9'd200, 9'd100, 9'd50,
    9'd100, 9'd100, 9'd220, 9'd220, 9'd400, 9'd400, 9'd500, 9'd500, 9'd500,
    9'd300, 9'd300, 9'd0,
    9'd0, 9'd0, 9'd200, 9'd250, 9'd380, 9'd500, 9'd500
  };

  localparam logic [5:0] CURVE_BASE [CURVES] = '{6'd0, 6'd8, 6'd23, 6'd28, 6'd37, 6'd40};
  localparam logic [3:0] CURVE_LAST [CURVES] = '{4'd7, 4'd14, 4'd4, 4'd8, 4'd2, 4'd6};

  localparam logic [17:0] CAP_RESET   = 18'd50000;
  localparam logic [26:0] RECIP_100   = 27'd85899346;
  localparam int          RECIP_SHIFT = 33;
  localparam logic [19:0] OUT_MAX     = 20'hFFFFF;

  localparam int QW = 9;
  localparam int DW = 14;
  localparam int NW = 23;

endpackage

@@ src/bcd_rom.sv @@
// Breakpoint table memory with a registered read port.
// Depends on bcd_pkg for the tables and the entry type.
module bcd_rom (
  input  logic            clk,
  input  logic [5:0]      addr,
  output bcd_pkg::entry_t data
);

  always_ff @(posedge clk) begin
    if (addr < 6'(bcd_pkg::TAB_N)) begin
      data.bp <= bcd_pkg::BP_TAB[addr];
      data.rt <= bcd_pkg::RT_TAB[addr];
    end else begin
      data <= '0;
    end
  end

endmodule

@@ src/bcd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on bcd_pkg for operand widths; the quotient must fit in QW bits.
module bcd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bcd_pkg::NW-1:0]    num,
  input  logic [bcd_pkg::DW-1:0]    den,
  output logic                      done,
  output logic [bcd_pkg::QW-1:0]    quo
);

  localparam int SW = bcd_pkg::DW + bcd_pkg::QW - 1;

  logic                   busy;
  logic [3:0]             cnt;
  logic [bcd_pkg::NW-1:0] rem;
  logic [SW-1:0]          dsh;
  logic [bcd_pkg::NW-1:0] dext;
  logic                   fit;

  assign dext = bcd_pkg::NW'(dsh);
  assign fit  = (dext <= rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= num;
      dsh <= {den, {(bcd_pkg::QW-1){1'b0}}};
      cnt <= 4'(bcd_pkg::QW - 1);
      quo <= '0;
    end else if (busy) begin
      if (fit) begin
        rem <= rem - dext;
      end
      quo <= {quo[bcd_pkg::QW-2:0], fit};
      dsh <= dsh >> 1;
      cnt <= cnt - 4'd1;
    end
  end

endmodule

@@ src/bcd_scale.sv @@
// Rate to milliamp scaling pipeline: rate * capacity / 100, saturated.
// Three stages; the divide by 100 is a reciprocal multiply. Depends on bcd_pkg.
module bcd_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic [17:0]         capacity,
  input  bcd_pkg::scale_req_t req,
  output bcd_pkg::scale_rsp_t rsp
);

  logic        v1, v2, t1, t2;
  logic [26:0] p1;
  logic [53:0] p2;
  logic [20:0] q;

  assign q = p2[bcd_pkg::RECIP_SHIFT +: 21];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1        <= req.valid;
      v2        <= v1;
      rsp.valid <= v2;
    end
    t1      <= req.tag;
    t2      <= t1;
    rsp.tag <= t2;
    p1      <= 27'(req.rate) * 27'(capacity);
    p2      <= 54'(p1) * 54'(bcd_pkg::RECIP_100);
    rsp.ma  <= (q > 21'(bcd_pkg::OUT_MAX)) ? bcd_pkg::OUT_MAX : q[19:0];
  end

endmodule

@@ src/battery_current_derating.sv @@
// Top level of the battery current derating block: sequencer, scratch memory,
// configuration register and ports. Uses bcd_pkg, bcd_rom, bcd_div, bcd_scale.
//
// channel   signals                          direction  handshake
// command   start, busy, item                in         beat when start && !busy
// result    done, result                     out        one-cycle strobe on done
// config    cfg_valid, cfg_ready, cfg_data   in         beat when valid && ready
//
// For each item the six curves are walked one table entry a cycle from the
// breakpoint memory, each interpolated segment goes through the 9-step
// divider, and scaling then turns the two lowest rates into milliamp limits.
// Reset clears the sequencer and restores capacity to 50000 mAh.
// One item is in flight at a time; busy stays high until done is strobed.
// The receiver cannot stall; result is updated when done is strobed and holds until the next one.
module battery_current_derating (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bcd_pkg::in_t    item,
  output logic            done,
  output bcd_pkg::out_t   result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [17:0]     cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_FILL = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_DIVG = 4'd4;
  localparam logic [3:0] S_DIVW = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_F0   = 4'd7;
  localparam logic [3:0] S_F1   = 4'd8;
  localparam logic [3:0] S_F2   = 4'd9;
  localparam logic [3:0] S_F3   = 4'd10;
  localparam logic [3:0] S_F4   = 4'd11;

  logic [3:0]             state;
  logic [2:0]             curve;
  logic [5:0]             idx;
  logic [3:0]             pos;
  logic [17:0]            capacity;
  bcd_pkg::in_t           item_q;
  logic signed [14:0]     prev_bp;
  logic [8:0]             prev_rt;
  logic [8:0]             rate;
  logic                   dy_neg;
  logic [bcd_pkg::NW-1:0] numer;
  logic [bcd_pkg::DW-1:0] den;
  logic [19:0]            chg_ma;

  bcd_pkg::entry_t        rd;
  logic                   div_done;
  logic [bcd_pkg::QW-1:0] quo;
  bcd_pkg::scale_req_t    sc_req;
  bcd_pkg::scale_rsp_t    sc_rsp;

  logic [8:0]             min_mem [2];
  logic [8:0]             min_rd;
  logic                   mem_we;
  logic [8:0]             mem_wd;

  logic signed [14:0]     x;
  logic signed [9:0]      dy;
  logic [8:0]             dy_abs;
  logic signed [15:0]     dx_in;
  logic signed [15:0]     dx_seg;
  logic                   hit;
  logic [2:0]             cnext;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (curve)
      3'd0, 3'd1: x = {{3{item_q.max_temperature[11]}}, item_q.max_temperature};
      3'd2, 3'd3: x = {1'b0, item_q.charge_state};
      3'd4:       x = {2'b00, item_q.highest_cell_mv};
      default:    x = {2'b00, item_q.lowest_cell_mv};
    endcase
  end

  assign dy     = signed'({1'b0, rd.rt}) - signed'({1'b0, prev_rt});
  assign dy_abs = dy[9] ? 9'(-dy) : dy[8:0];
  assign dx_in  = {x[14], x} - {prev_bp[14], prev_bp};
  assign dx_seg = {rd.bp[14], rd.bp} - {prev_bp[14], prev_bp};
  assign hit    = (x <= rd.bp);
  assign cnext  = curve + 3'd1;

  assign mem_we = (state == S_UPD);
  assign mem_wd = (curve < 3'd2 || rate < min_rd) ? rate : min_rd;

  assign sc_req.valid = (state == S_F1) || (state == S_F3);
  assign sc_req.tag   = (state == S_F3);
  assign sc_req.rate  = min_rd;

  bcd_rom u_rom (
    .clk  (clk),
    .addr (idx),
    .data (rd)
  );

  bcd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVG),
    .num   (numer),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  bcd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .req      (sc_req),
    .rsp      (sc_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      min_mem[curve[0]] <= mem_wd;
    end
    min_rd <= min_mem[curve[0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bcd_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            curve  <= 3'd0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          idx   <= bcd_pkg::CURVE_BASE[curve];
          state <= S_FILL;
        end
        S_FILL: begin
          idx   <= idx + 6'd1;
          pos   <= 4'd0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          idx <= idx + 6'd1;
          pos <= pos + 4'd1;
          if (pos == 4'd0 && hit) begin
            rate  <= rd.rt;
            state <= S_UPD;
          end else if (pos != 4'd0 && hit) begin
            numer  <= bcd_pkg::NW'(dy_abs) * bcd_pkg::NW'(dx_in[13:0]);
            den    <= dx_seg[13:0];
            dy_neg <= dy[9];
            state  <= S_DIVG;
          end else if (pos == bcd_pkg::CURVE_LAST[curve]) begin
            rate  <= rd.rt;
            state <= S_UPD;
          end else begin
            prev_bp <= rd.bp;
            prev_rt <= rd.rt;
          end
        end
        S_DIVG: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            rate  <= dy_neg ? prev_rt - quo : prev_rt + quo;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          curve <= cnext;
          state <= (curve == 3'd5) ? S_F0 : S_LOAD;
        end
        S_F0: begin
          state <= S_F1;
        end
        S_F1: begin
          curve <= 3'd7;
          state <= S_F2;
        end
        S_F2: begin
          state <= S_F3;
        end
        S_F3: begin
          state <= S_F4;
        end
        S_F4: begin
          if (sc_rsp.valid && sc_rsp.tag) begin
            result.charge_limit_ma    <= chg_ma;
            result.discharge_limit_ma <= sc_rsp.ma;
            done                      <= 1'b1;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (sc_rsp.valid && !sc_rsp.tag) begin
      chg_ma <= sc_rsp.ma;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider finished outside its wait state");

  a_scale_last: assert property (@(posedge clk) disable iff (rst)
    (sc_rsp.valid && sc_rsp.tag) |-> (state == S_F4))
    else $error("discharge scaling beat arrived out of sequence");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for battery_current_derating: drives pack snapshots,
// predicts both current limits from breakpoint curves and compares every result.
// Depends on bcd_pkg and battery_current_derating.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    CHG_TEMP, DIS_TEMP, CHG_SOC, DIS_SOC, CHG_CELL, DIS_CELL
  } curve_e;

  localparam int KNEE_X [47] = '{
    -250, 0, 50, 150, 350, 450, 550, 650,
    -250, -150, -100, -50, 0, 50, 100, 250, 300, 350, 450, 550, 600, 650, 700,
    0, 8500, 9000, 9500, 10000,
    0, 200, 500, 800, 1000, 1500, 2000, 5000, 10000,
    3000, 4100, 4200,
    3000, 3200, 3300, 3400, 3450, 3550, 4200
  };
  localparam int KNEE_Y [47] = '{
    0, 0, 0, 300, 300, 200, 0, 0,
    20, 20, 100, 150, 200, 450, 500, 500, 450, 400, 380, 380, 20, 20, 0,
    300, 300, 200, 100, 50,
    100, 100, 220, 220, 400, 400, 500, 500, 500,
    300, 300, 0,
    0, 0, 200, 250, 380, 500, 500
  };
  localparam int CURVE_FIRST [6] = '{0, 8, 23, 28, 37, 40};
  localparam int CURVE_SPAN  [6] = '{7, 14, 4, 8, 2, 6};
  localparam longint LIMIT_MAX = 1048575;

  logic           clk;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  bcd_pkg::in_t   item = '0;
  logic           done;
  bcd_pkg::out_t  result;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [17:0]    cfg_data = '0;

  logic [17:0]    capacity_now = 18'd50000;
  bcd_pkg::out_t  limits_due [$];
  int             mismatches = 0;
  bit             gaps_on = 1'b1;

  battery_current_derating i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint curve_rate(curve_e c, longint x);
    int     b;
    int     n;
    longint dx;
    longint dy;
    b = CURVE_FIRST[int'(c)];
    n = CURVE_SPAN[int'(c)];
    if (x <= KNEE_X[b]) return KNEE_Y[b];
    if (x >= KNEE_X[b + n]) return KNEE_Y[b + n];
    for (int i = 1; i <= n; i++) begin
      if (x <= KNEE_X[b + i]) begin
        dx = KNEE_X[b + i] - KNEE_X[b + i - 1];
        dy = KNEE_Y[b + i] - KNEE_Y[b + i - 1];
        if (dx == 0) return KNEE_Y[b + i];
        return KNEE_Y[b + i - 1] + (dy * (x - KNEE_X[b + i - 1])) / dx;
      end
    end
    return KNEE_Y[b + n];
  endfunction

  function automatic longint rate_to_ma(longint rate);
    longint ma;
    ma = (rate * longint'(capacity_now)) / 100;
    if (ma > LIMIT_MAX) ma = LIMIT_MAX;
    return ma;
  endfunction

  function automatic longint lowest_of(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    m = (m < c) ? m : c;
    return (m < 0) ? 0 : m;
  endfunction

  function automatic bcd_pkg::out_t derate(bcd_pkg::in_t r);
    bcd_pkg::out_t o;
    longint        t;
    t = longint'($signed(r.max_temperature));
    o.charge_limit_ma = 20'(lowest_of(rate_to_ma(curve_rate(CHG_TEMP, t)),
                                      rate_to_ma(curve_rate(CHG_SOC, r.charge_state)),
                                      rate_to_ma(curve_rate(CHG_CELL, r.highest_cell_mv))));
    o.discharge_limit_ma = 20'(lowest_of(rate_to_ma(curve_rate(DIS_TEMP, t)),
                                         rate_to_ma(curve_rate(DIS_SOC, r.charge_state)),
                                         rate_to_ma(curve_rate(DIS_CELL, r.lowest_cell_mv))));
    return o;
  endfunction

  function automatic bcd_pkg::in_t make_reading(int t, int s, int h, int l);
    bcd_pkg::in_t r;
    r.max_temperature = 12'(t);
    r.charge_state    = 14'(s);
    r.highest_cell_mv = 13'(h);
    r.lowest_cell_mv  = 13'(l);
    return r;
  endfunction

  function automatic bcd_pkg::in_t random_reading();
    bcd_pkg::in_t r;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) r.max_temperature = 12'(int'($urandom_range(0, 2050)) - 550);
    else r.max_temperature = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) r.charge_state = 14'($urandom_range(0, 10000));
    else if (pick < 90) r.charge_state = 14'($urandom_range(8000, 10000));
    else r.charge_state = 14'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) r.highest_cell_mv = 13'($urandom_range(2900, 4300));
    else if (pick < 85) r.highest_cell_mv = 13'($urandom_range(0, 5000));
    else r.highest_cell_mv = 13'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) r.lowest_cell_mv = 13'($urandom_range(2900, 4300));
    else if (pick < 85) r.lowest_cell_mv = 13'($urandom_range(0, 5000));
    else r.lowest_cell_mv = 13'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Hold start high across back-to-back beats; drop it only for an idle burst.
  task automatic send_reading(bcd_pkg::in_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item  <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    limits_due.push_back(derate(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (limits_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [17:0] cap);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity_now = cap;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    bcd_pkg::out_t want;
    if (!rst && done === 1'b1) begin
      if (limits_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", result));
      end else begin
        want = limits_due.pop_front();
        if (result.charge_limit_ma !== want.charge_limit_ma)
          report_mismatch($sformatf("charge_limit_ma %0d, expected %0d",
                                    result.charge_limit_ma, want.charge_limit_ma));
        if (result.discharge_limit_ma !== want.discharge_limit_ma)
          report_mismatch($sformatf("discharge_limit_ma %0d, expected %0d",
                                    result.discharge_limit_ma, want.discharge_limit_ma));
      end
    end
  end

  task automatic test_breakpoints();
    send_reading(make_reading(-2048, 0, 0, 0));
    send_reading(make_reading(2047, 16383, 8191, 8191));
    send_reading(make_reading(-550, 10000, 5000, 5000));
    send_reading(make_reading(1500, 0, 3000, 3000));
    send_reading(make_reading(-250, 8500, 4100, 3200));
    send_reading(make_reading(0, 9000, 4200, 3300));
    send_reading(make_reading(50, 9500, 4150, 3425));
    send_reading(make_reading(150, 8750, 3050, 3500));
    send_reading(make_reading(250, 100, 4199, 3449));
    send_reading(make_reading(400, 350, 4101, 3551));
    send_reading(make_reading(500, 650, 2999, 4200));
    send_reading(make_reading(575, 900, 3999, 3301));
    send_reading(make_reading(625, 1250, 4000, 3401));
    send_reading(make_reading(675, 1750, 4050, 2999));
    send_reading(make_reading(700, 3500, 4250, 4300));
    send_reading(make_reading(-1, 7000, 4175, 3275));
    send_reading(make_reading(-200, 20, 3333, 3333));
    send_reading(make_reading(-120, 8999, 3777, 3210));
    send_reading(make_reading(-75, 9999, 4123, 3375));
    send_reading(make_reading(325, 10001, 4099, 3499));
    send_reading(make_reading(1024, 12345, 6000, 7000));
    drain();
  endtask

  task automatic test_capacity_extremes();
    write_capacity(18'd0);
    send_reading(make_reading(250, 0, 3000, 4000));
    send_reading(make_reading(100, 3000, 3500, 3600));
    drain();
    write_capacity(18'h3FFFF);
    send_reading(make_reading(250, 0, 3000, 4000));
    send_reading(make_reading(150, 2500, 3500, 3600));
    send_reading(make_reading(50, 9200, 4180, 3420));
    drain();
    write_capacity(18'd1);
    send_reading(make_reading(250, 0, 3000, 4000));
    send_reading(make_reading(75, 600, 4150, 3420));
    drain();
    write_capacity(18'd200000);
    send_reading(make_reading(250, 0, 3000, 4000));
    send_reading(make_reading(75, 600, 4150, 3420));
    drain();
  endtask

  task automatic test_random_snapshots();
    logic [17:0] caps [8];
    caps = '{18'd50000, 18'd200000, 18'h3FFFF, 18'd0, 18'd1, 18'd0, 18'd0, 18'd50000};
    caps[5] = 18'($urandom_range(1, 200000));
    caps[6] = 18'($urandom);
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      gaps_on = (p != 7);
      repeat (250) send_reading(random_reading());
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_breakpoints();
    test_capacity_extremes();
    test_random_snapshots();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && limits_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
